@@ src/ndrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NDEF record parser package
// Shared phase codes, header bit positions, result word layout and the
// helper that picks the next non-empty body section of a record.
// ----------------------------------------------------------------------------
package ndrp_pkg;

    localparam int MAX_RECORDS_DEF = 4;

    // Header byte bit positions.
    localparam int HdrMeBit = 6;
    localparam int HdrSrBit = 4;
    localparam int HdrIlBit = 3;

    // The long payload length takes four bytes; the count wraps at this value.
    localparam logic [1:0] LenLastByte = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER      = 3'd0,
        PH_TYPE_LEN    = 3'd1,
        PH_PAYLOAD_LEN = 3'd2,
        PH_ID_LEN      = 3'd3,
        PH_TYPE        = 3'd4,
        PH_ID          = 3'd5,
        PH_PAYLOAD     = 3'd6,
        PH_IGNORE      = 3'd7
    } t_phase;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  field_kind;
        logic [2:0]  record_index;
        logic [2:0]  record_tnf;
        logic [7:0]  type_length;
        logic [7:0]  id_length;
        logic [31:0] payload_length;
        logic        record_done;
        logic        message_done;
        logic        record_dropped;
        logic        truncated;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] remaining;
        logic        empty;
    } t_section;

    // First body section at or after the given phase whose length is not zero.
    function automatic t_section enter_section(
        input t_phase      from,
        input logic [7:0]  type_len,
        input logic        il_flag,
        input logic [7:0]  id_len,
        input logic [31:0] payload_len
    );
        t_section s;
        s.phase     = PH_HEADER;
        s.remaining = '0;
        s.empty     = 1'b1;
        if (from <= PH_TYPE && type_len != 8'd0) begin
            s.phase     = PH_TYPE;
            s.remaining = {24'd0, type_len};
            s.empty     = 1'b0;
        end else if (from <= PH_ID && il_flag && id_len != 8'd0) begin
            s.phase     = PH_ID;
            s.remaining = {24'd0, id_len};
            s.empty     = 1'b0;
        end else if (from <= PH_PAYLOAD && payload_len != 32'd0) begin
            s.phase     = PH_PAYLOAD;
            s.remaining = payload_len;
            s.empty     = 1'b0;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

@@ src/ndrp_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NDEF parser input register
// Captures one message byte and its last-byte mark when the input side
// is ready.
// ----------------------------------------------------------------------------
module ndrp_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    output logic [7:0]      o_data_byte,
    output logic            o_last_byte
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_data_byte <= i_data_byte;
            r_last_byte <= i_last_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data_byte;
    assign o_last_byte = r_last_byte;

endmodule
`default_nettype wire

@@ src/ndrp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NDEF parser core
// Holds the record parse state and classifies the registered byte in a
// single pass of logic; state moves only when the byte is handed on.
// ----------------------------------------------------------------------------
module ndrp_parser #(
    parameter int MAX_RECORDS = ndrp_pkg::MAX_RECORDS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output ndrp_pkg::t_result o_result
);

    localparam int CntW = $clog2(MAX_RECORDS + 1);

    ndrp_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_remaining, n_remaining;
    logic [1:0]       r_len_cnt, n_len_cnt;
    logic [7:0]       r_type_len, n_type_len;
    logic [7:0]       r_id_len, n_id_len;
    logic [31:0]      r_payload_len, n_payload_len;
    logic             r_me, n_me;
    logic             r_sr, n_sr;
    logic             r_il, n_il;
    logic [2:0]       r_tnf, n_tnf;
    logic [CntW-1:0]  r_count, n_count;

    ndrp_pkg::t_phase   sec_from;
    ndrp_pkg::t_section sec;
    ndrp_pkg::t_result  res;
    logic               sec_req;
    logic               done;
    logic               dropped;
    logic               ignored;
    logic [31:0]        len_shift;
    logic [31:0]        body_left;
    logic [CntW+2:0]    idx_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ndrp_pkg::PH_HEADER;
            r_remaining   <= '0;
            r_len_cnt     <= '0;
            r_type_len    <= '0;
            r_id_len      <= '0;
            r_payload_len <= '0;
            r_me          <= 1'b0;
            r_sr          <= 1'b0;
            r_il          <= 1'b0;
            r_tnf         <= '0;
            r_count       <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_remaining   <= n_remaining;
            r_len_cnt     <= n_len_cnt;
            r_type_len    <= n_type_len;
            r_id_len      <= n_id_len;
            r_payload_len <= n_payload_len;
            r_me          <= n_me;
            r_sr          <= n_sr;
            r_il          <= n_il;
            r_tnf         <= n_tnf;
            r_count       <= n_count;
        end
    end

    assign len_shift = {r_remaining[23:0], i_data_byte};
    assign body_left = (r_remaining != 32'd0) ? r_remaining - 32'd1 : r_remaining;
    assign idx_wide  = {3'd0, r_count};
    assign ignored   = (r_phase == ndrp_pkg::PH_IGNORE);

    always_comb begin
        n_phase       = r_phase;
        n_remaining   = r_remaining;
        n_len_cnt     = r_len_cnt;
        n_type_len    = r_type_len;
        n_id_len      = r_id_len;
        n_payload_len = r_payload_len;
        n_me          = r_me;
        n_sr          = r_sr;
        n_il          = r_il;
        n_tnf         = r_tnf;
        n_count       = r_count;
        sec_req       = 1'b0;
        sec_from      = ndrp_pkg::PH_TYPE;
        done          = 1'b0;
        dropped       = 1'b0;

        case (r_phase)
            ndrp_pkg::PH_HEADER: begin
                n_me          = i_data_byte[ndrp_pkg::HdrMeBit];
                n_sr          = i_data_byte[ndrp_pkg::HdrSrBit];
                n_il          = i_data_byte[ndrp_pkg::HdrIlBit];
                n_tnf         = i_data_byte[2:0];
                n_type_len    = '0;
                n_id_len      = '0;
                n_payload_len = '0;
                n_phase       = ndrp_pkg::PH_TYPE_LEN;
            end
            ndrp_pkg::PH_TYPE_LEN: begin
                n_type_len  = i_data_byte;
                n_len_cnt   = '0;
                n_remaining = '0;
                n_phase     = ndrp_pkg::PH_PAYLOAD_LEN;
            end
            ndrp_pkg::PH_PAYLOAD_LEN: begin
                if (r_sr) begin
                    n_payload_len = {24'd0, i_data_byte};
                    sec_req       = 1'b1;
                end else if (r_len_cnt == ndrp_pkg::LenLastByte) begin
                    n_payload_len = len_shift;
                    sec_req       = 1'b1;
                end else begin
                    n_remaining = len_shift;
                    n_len_cnt   = r_len_cnt + 2'd1;
                end
                if (sec_req) begin
                    n_len_cnt   = '0;
                    n_remaining = '0;
                    if (r_il) begin
                        sec_req = 1'b0;
                        n_phase = ndrp_pkg::PH_ID_LEN;
                    end
                end
            end
            ndrp_pkg::PH_ID_LEN: begin
                n_id_len = i_data_byte;
                sec_req  = 1'b1;
            end
            ndrp_pkg::PH_IGNORE: begin
                n_phase = r_phase;
            end
            default: begin
                n_remaining = body_left;
                if (body_left == 32'd0) begin
                    if (r_phase == ndrp_pkg::PH_PAYLOAD) begin
                        done = 1'b1;
                    end else begin
                        sec_req  = 1'b1;
                        sec_from = ndrp_pkg::t_phase'(r_phase + 3'd1);
                    end
                end
            end
        endcase

        // The section search looks at the lengths as they stand after this byte.
        sec = ndrp_pkg::enter_section(sec_from, n_type_len, n_il, n_id_len, n_payload_len);

        if (sec_req) begin
            if (sec.empty) begin
                done = 1'b1;
            end else begin
                n_phase     = sec.phase;
                n_remaining = sec.remaining;
            end
        end

        if (done) begin
            dropped     = (r_count >= CntW'(MAX_RECORDS));
            n_count     = dropped ? r_count : r_count + CntW'(1);
            n_remaining = '0;
            n_phase     = r_me ? ndrp_pkg::PH_IGNORE : ndrp_pkg::PH_HEADER;
        end

        res.byte_value = i_data_byte;
        res.field_kind = r_phase;
        if (ignored) begin
            res.record_index   = '0;
            res.record_tnf     = '0;
            res.type_length    = '0;
            res.id_length      = '0;
            res.payload_length = '0;
        end else begin
            res.record_index   = idx_wide[2:0];
            res.record_tnf     = n_tnf;
            res.type_length    = n_type_len;
            res.id_length      = n_id_len;
            res.payload_length = n_payload_len;
        end
        res.record_done    = done;
        res.message_done   = done && r_me;
        res.record_dropped = dropped;
        res.truncated      = i_last_byte && !done && !ignored;

        // The end of the buffer returns the parser to its reset state.
        if (i_last_byte) begin
            n_phase       = ndrp_pkg::PH_HEADER;
            n_remaining   = '0;
            n_len_cnt     = '0;
            n_type_len    = '0;
            n_id_len      = '0;
            n_payload_len = '0;
            n_me          = 1'b0;
            n_sr          = 1'b0;
            n_il          = 1'b0;
            n_tnf         = '0;
            n_count       = '0;
        end
    end

    assign o_result = res;

    a_msg_needs_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.message_done |-> res.record_done)
        else $error("message end reported without a record end");

    a_trunc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(res.truncated && res.record_done))
        else $error("truncation flagged on a completing byte");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && ignored |-> !res.record_done && !res.truncated
            && res.payload_length == 32'd0 && res.record_index == 3'd0)
        else $error("ignored byte carries record data");

    a_next_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.record_done && !res.message_done && !i_last_byte
            |=> r_phase == ndrp_pkg::PH_HEADER)
        else $error("parser did not return to header after a record");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_RECORDS))
        else $error("record count passed its limit");

endmodule
`default_nettype wire

@@ src/ndrp_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NDEF parser result register
// Holds one classified byte until the downstream side takes it.
// ----------------------------------------------------------------------------
module ndrp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_valid,
    input  wire ndrp_pkg::t_result i_result,
    output logic                   o_valid,
    output ndrp_pkg::t_result      o_result
);

    logic              r_valid;
    ndrp_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

@@ src/ndef_record_stream_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NDEF record stream parser
// Classifies each byte of an NDEF message as header, length or body byte.
// ----------------------------------------------------------------------------
// The parser returns one result word per message byte, in order; a byte is
// held in the input register and its word in the result register. When the
// output is not stalled, throughput is one byte per cycle: the header,
// length and body bookkeeping for a byte is a single pass of logic between
// the input register and the result register. Each word reports the field
// kind, the record index (MAX_RECORDS once the limit is reached), the TNF
// and the lengths known so far, and marks record end, message end, dropped
// records and a buffer that ends partway through a record. After the last
// byte of a buffer the parser is back in its reset state.
// ----------------------------------------------------------------------------
module ndef_record_stream_parser_unit #(
    parameter int MAX_RECORDS = ndrp_pkg::MAX_RECORDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_byte_value,
    output logic [2:0]       o_field_kind,
    output logic [2:0]       o_record_index,
    output logic [2:0]       o_record_tnf,
    output logic [7:0]       o_type_length,
    output logic [7:0]       o_id_length,
    output logic [31:0]      o_payload_length,
    output logic             o_record_done,
    output logic             o_message_done,
    output logic             o_record_dropped,
    output logic             o_truncated
);

    logic              advance;
    logic              in_valid;
    logic [7:0]        in_byte;
    logic              in_last;
    ndrp_pkg::t_result core_res;
    ndrp_pkg::t_result out_res;

    // A word moves on when the result register is empty or being emptied.
    assign advance = !o_valid || i_ready;
    assign o_ready = !in_valid || advance;

    ndrp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (o_ready),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (in_valid),
        .o_data_byte (in_byte),
        .o_last_byte (in_last)
    );

    ndrp_parser #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_valid && advance),
        .i_data_byte (in_byte),
        .i_last_byte (in_last),
        .o_result    (core_res)
    );

    ndrp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_valid  (in_valid),
        .i_result (core_res),
        .o_valid  (o_valid),
        .o_result (out_res)
    );

    assign o_byte_value     = out_res.byte_value;
    assign o_field_kind     = out_res.field_kind;
    assign o_record_index   = out_res.record_index;
    assign o_record_tnf     = out_res.record_tnf;
    assign o_type_length    = out_res.type_length;
    assign o_id_length      = out_res.id_length;
    assign o_payload_length = out_res.payload_length;
    assign o_record_done    = out_res.record_done;
    assign o_message_done   = out_res.message_done;
    assign o_record_dropped = out_res.record_dropped;
    assign o_truncated      = out_res.truncated;

endmodule
`default_nettype wire

@@ tb/ndef_parse_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF parser result checker
// Watches both channels of the record stream parser. Every accepted input
// word is run through a byte classifier with its own copy of the parse state,
// and the expected result word is queued. Every accepted result word is
// compared field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module ndef_parse_checker #(
    parameter int MAX_RECORDS = ndrp_pkg::MAX_RECORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_byte_value,
    input  logic [2:0]  i_field_kind,
    input  logic [2:0]  i_record_index,
    input  logic [2:0]  i_record_tnf,
    input  logic [7:0]  i_type_length,
    input  logic [7:0]  i_id_length,
    input  logic [31:0] i_payload_length,
    input  logic        i_record_done,
    input  logic        i_message_done,
    input  logic        i_record_dropped,
    input  logic        i_truncated,
    output int          o_pending,
    output int          o_fail_count
);
    import ndrp_pkg::*;

    // Parse state of the classifier.
    t_phase      cur_phase;
    logic [31:0] body_left;
    logic [1:0]  len_bytes_seen;
    logic [7:0]  rec_type_len;
    logic [7:0]  rec_id_len;
    logic [31:0] rec_payload_len;
    logic        rec_me;
    logic        rec_sr;
    logic        rec_il;
    logic [2:0]  rec_tnf;
    int          stored_records;
    logic        past_end;

    t_result expected_words[$];
    int      mismatches = 0;
    int      words_in_flight = 0;

    assign o_pending    = words_in_flight;
    assign o_fail_count = mismatches;

    task automatic restart_parse();
        cur_phase       = PH_HEADER;
        body_left       = '0;
        len_bytes_seen  = '0;
        rec_type_len    = '0;
        rec_id_len      = '0;
        rec_payload_len = '0;
        rec_me          = 1'b0;
        rec_sr          = 1'b0;
        rec_il          = 1'b0;
        rec_tnf         = '0;
        stored_records  = 0;
        past_end        = 1'b0;
    endtask

    // Moves to the first body section at or after 'from' that has bytes in it.
    // Sets none_left when the record has no such section.
    task automatic open_body(input t_phase from, output logic none_left);
        none_left = 1'b0;
        if (from <= PH_TYPE && rec_type_len != 8'd0) begin
            cur_phase = PH_TYPE;
            body_left = {24'd0, rec_type_len};
        end else if (from <= PH_ID && rec_il && rec_id_len != 8'd0) begin
            cur_phase = PH_ID;
            body_left = {24'd0, rec_id_len};
        end else if (from <= PH_PAYLOAD && rec_payload_len != 32'd0) begin
            cur_phase = PH_PAYLOAD;
            body_left = rec_payload_len;
        end else begin
            none_left = 1'b1;
        end
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic last, output t_result r);
        logic   finished;
        logic   skipped;
        logic   len_ready;
        t_phase kind;
        finished  = 1'b0;
        skipped   = 1'b0;
        len_ready = 1'b0;
        r         = '0;
        if (past_end || cur_phase == PH_IGNORE) begin
            kind    = PH_IGNORE;
            skipped = 1'b1;
        end else begin
            kind = cur_phase;
            case (cur_phase)
                PH_HEADER: begin
                    rec_me          = b[HdrMeBit];
                    rec_sr          = b[HdrSrBit];
                    rec_il          = b[HdrIlBit];
                    rec_tnf         = b[2:0];
                    rec_type_len    = '0;
                    rec_id_len      = '0;
                    rec_payload_len = '0;
                    cur_phase       = PH_TYPE_LEN;
                end
                PH_TYPE_LEN: begin
                    rec_type_len   = b;
                    len_bytes_seen = '0;
                    body_left      = '0;
                    cur_phase      = PH_PAYLOAD_LEN;
                end
                PH_PAYLOAD_LEN: begin
                    if (rec_sr) begin
                        rec_payload_len = {24'd0, b};
                        len_ready       = 1'b1;
                    end else begin
                        // The long length is gathered most significant byte first.
                        body_left = {body_left[23:0], b};
                        if (len_bytes_seen == LenLastByte) begin
                            rec_payload_len = body_left;
                            len_ready       = 1'b1;
                        end else begin
                            len_bytes_seen = len_bytes_seen + 2'd1;
                        end
                    end
                    if (len_ready) begin
                        len_bytes_seen = '0;
                        body_left      = '0;
                        if (rec_il) begin
                            cur_phase = PH_ID_LEN;
                        end else begin
                            open_body(PH_TYPE, finished);
                        end
                    end
                end
                PH_ID_LEN: begin
                    rec_id_len = b;
                    open_body(PH_TYPE, finished);
                end
                default: begin
                    if (body_left != 32'd0) begin
                        body_left = body_left - 32'd1;
                    end
                    if (body_left == 32'd0) begin
                        if (cur_phase == PH_PAYLOAD) begin
                            finished = 1'b1;
                        end else begin
                            open_body(t_phase'(cur_phase + 1), finished);
                        end
                    end
                end
            endcase
        end

        r.byte_value = b;
        r.field_kind = kind;
        if (!skipped) begin
            r.record_index   = (stored_records < MAX_RECORDS) ? 3'(stored_records)
                                                              : 3'(MAX_RECORDS);
            r.record_tnf     = rec_tnf;
            r.type_length    = rec_type_len;
            r.id_length      = rec_id_len;
            r.payload_length = rec_payload_len;
        end
        if (finished) begin
            r.record_dropped = stored_records >= MAX_RECORDS;
            if (!r.record_dropped) begin
                stored_records++;
            end
            r.message_done = rec_me;
            body_left      = '0;
            if (rec_me) begin
                past_end  = 1'b1;
                cur_phase = PH_IGNORE;
            end else begin
                cur_phase = PH_HEADER;
            end
        end
        r.record_done = finished;
        r.truncated   = last && !finished && !skipped;
        if (last) begin
            restart_parse();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result predicted;
        t_result want;
        if (!i_rst_n) begin
            restart_parse();
            expected_words.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                classify_byte(i_data_byte, i_last_byte, predicted);
                expected_words.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word arrived with no expected word waiting");
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("byte_value", want.byte_value, i_byte_value);
                    check_field("field_kind", want.field_kind, i_field_kind);
                    check_field("record_index", want.record_index, i_record_index);
                    check_field("record_tnf", want.record_tnf, i_record_tnf);
                    check_field("type_length", want.type_length, i_type_length);
                    check_field("id_length", want.id_length, i_id_length);
                    check_field("payload_length", want.payload_length, i_payload_length);
                    check_field("record_done", want.record_done, i_record_done);
                    check_field("message_done", want.message_done, i_message_done);
                    check_field("record_dropped", want.record_dropped, i_record_dropped);
                    check_field("truncated", want.truncated, i_truncated);
                end
            end
        end
        words_in_flight = expected_words.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF record stream parser testbench
// Feeds directed buffers (record limit, empty bodies, long lengths, buffers
// that end inside a record) and then random buffers: mostly well-formed
// messages with random content, some cut short and some pure noise, with
// random gaps and stalls on both channels. The checker does all comparing.
// ----------------------------------------------------------------------------
module testbench;
    import ndrp_pkg::*;

    localparam int WORD_TARGET = 1150;
    localparam int HOLD_CYCLES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_byte_value;
    logic [2:0]  o_field_kind;
    logic [2:0]  o_record_index;
    logic [2:0]  o_record_tnf;
    logic [7:0]  o_type_length;
    logic [7:0]  o_id_length;
    logic [31:0] o_payload_length;
    logic        o_record_done;
    logic        o_message_done;
    logic        o_record_dropped;
    logic        o_truncated;

    int   pending;
    int   fail_count;
    int   words_sent = 0;
    int   buffer_count = 0;
    bit   steady = 1'b0;
    bit   hold_req = 1'b0;
    logic [7:0] msg_bytes[$];

    always #5 i_clk = ~i_clk;

    ndef_record_stream_parser_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_byte_value     (o_byte_value),
        .o_field_kind     (o_field_kind),
        .o_record_index   (o_record_index),
        .o_record_tnf     (o_record_tnf),
        .o_type_length    (o_type_length),
        .o_id_length      (o_id_length),
        .o_payload_length (o_payload_length),
        .o_record_done    (o_record_done),
        .o_message_done   (o_message_done),
        .o_record_dropped (o_record_dropped),
        .o_truncated      (o_truncated)
    );

    ndef_parse_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_byte_value     (o_byte_value),
        .i_field_kind     (o_field_kind),
        .i_record_index   (o_record_index),
        .i_record_tnf     (o_record_tnf),
        .i_type_length    (o_type_length),
        .i_id_length      (o_id_length),
        .i_payload_length (o_payload_length),
        .i_record_done    (o_record_done),
        .i_message_done   (o_message_done),
        .i_record_dropped (o_record_dropped),
        .i_truncated      (o_truncated),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    // Offers one word and returns at the edge where it is taken.
    task automatic push_word(input logic [7:0] b, input logic last);
        int gap;
        int pick;
        gap = 0;
        if (!steady) begin
            pick = $urandom_range(0, 99);
            if (pick >= 95) begin
                gap = $urandom_range(6, 25);
            end else if (pick >= 55) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_buffer();
        int i;
        for (i = 0; i < msg_bytes.size(); i++) begin
            push_word(msg_bytes[i], i == msg_bytes.size() - 1);
        end
    endtask

    // Appends one well-formed record with random flags, lengths and content.
    task automatic add_record(input logic me);
        logic [7:0]  hdr;
        logic [7:0]  type_len;
        logic [7:0]  id_len;
        logic [31:0] pay_len;
        int          j;
        hdr           = 8'($urandom_range(0, 255));
        hdr[HdrMeBit] = me;
        hdr[HdrSrBit] = $urandom_range(0, 3) != 0;
        hdr[HdrIlBit] = $urandom_range(0, 2) == 0;
        type_len = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 15) == 0) type_len = 8'($urandom_range(4, 40));
        id_len = 8'($urandom_range(0, 3));
        pay_len = $urandom_range(0, 8);
        if ($urandom_range(0, 15) == 0) pay_len = $urandom_range(9, 60);
        msg_bytes.push_back(hdr);
        msg_bytes.push_back(type_len);
        if (hdr[HdrSrBit]) begin
            msg_bytes.push_back(pay_len[7:0]);
        end else begin
            msg_bytes.push_back(pay_len[31:24]);
            msg_bytes.push_back(pay_len[23:16]);
            msg_bytes.push_back(pay_len[15:8]);
            msg_bytes.push_back(pay_len[7:0]);
        end
        if (hdr[HdrIlBit]) msg_bytes.push_back(id_len);
        for (j = 0; j < type_len; j++) msg_bytes.push_back(8'($urandom_range(0, 255)));
        if (hdr[HdrIlBit]) begin
            for (j = 0; j < id_len; j++) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        for (j = 0; j < pay_len; j++) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Stops offering and waits until every expected result word has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold on request.
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (steady || $urandom_range(0, 9) < 7) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 3);
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        int i;
        int nrec;
        int pick;
        int cut;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Four empty records fill the store; the fifth carries ME and is
        // dropped, and the byte after it is ignored.
        for (i = 0; i < 4; i++) begin
            push_word(8'h10 | 8'(i), 1'b0);
            push_word(8'h00, 1'b0);
            push_word(8'h00, 1'b0);
        end
        push_word(8'h57, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b1);
        // Long payload length with an id; the buffer ends on the completing byte.
        push_word(8'h2D, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'hA5, 1'b0);
        push_word(8'h5A, 1'b1);
        // The buffer ends inside a record.
        push_word(8'h01, 1'b0);
        push_word(8'hFF, 1'b1);
        wait_drained();

        while (words_sent < WORD_TARGET) begin
            msg_bytes.delete();
            steady = $urandom_range(0, 4) == 0;
            if (buffer_count == 8) begin
                // The receiver holds off while a long message streams in.
                hold_req = 1'b1;
                steady   = 1'b1;
                for (i = 0; i < 6; i++) add_record(i == 5);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    nrec = $urandom_range(1, 6);
                    for (i = 0; i < nrec; i++) begin
                        add_record(i == nrec - 1 && $urandom_range(0, 9) != 0);
                    end
                    repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(0, 255)));
                end else if (pick < 82) begin
                    nrec = $urandom_range(1, 4);
                    for (i = 0; i < nrec; i++) add_record(i == nrec - 1);
                    cut = $urandom_range(1, msg_bytes.size());
                    while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
                end else begin
                    repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            send_buffer();
            if (buffer_count == 20) wait_drained();
            buffer_count++;
        end

        steady = 1'b0;
        wait_drained();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ ndef_record_stream_parser_unit.f @@
src/ndrp_pkg.sv
src/ndrp_in_reg.sv
src/ndrp_parser.sv
src/ndrp_out_reg.sv
src/ndef_record_stream_parser_unit.sv
tb/ndef_parse_checker.sv
tb/testbench.sv
